>>> src/khsa_pkg.sv
// ----------------------------------------------------------------------------
// khsa_pkg
// Shared widths, reset values, key and register codes and the control
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package khsa_pkg;

  localparam int DAC_BITS   = 12;
  localparam int SP_BITS    = 10;
  localparam int KEY_W      = 5;
  localparam int HOLD_W     = 4;
  localparam int COARSE_W   = 7;
  localparam int OFFSET_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SP_BITS;

  // divider sizes: setpoint scaled by 2^DAC_BITS over (max + 1)
  localparam int DIVIDEND_W = SP_BITS + DAC_BITS;
  localparam int DIVISOR_W  = SP_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam int S_TDATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((SP_BITS + DAC_BITS + 7) / 8) * 8;
  localparam int M_TUSER_W  = 2;

  localparam logic [SP_BITS-1:0]  MAX_SP_RST   = SP_BITS'(499);
  localparam logic [HOLD_W-1:0]   HOLD_RST     = HOLD_W'(4);
  localparam logic [COARSE_W-1:0] COARSE_RST   = COARSE_W'(10);
  localparam logic [OFFSET_W-1:0] OFFSET_RST   = OFFSET_W'(50);
  localparam logic [SP_BITS-1:0]  SETPOINT_RST = SP_BITS'(10);

  // key codes
  localparam logic [KEY_W-1:0] KEY_NONE    = KEY_W'(0);
  localparam logic [KEY_W-1:0] KEY_UP      = KEY_W'(1);
  localparam logic [KEY_W-1:0] KEY_DOWN    = KEY_W'(2);
  localparam logic [KEY_W-1:0] KEY_C_UP    = KEY_W'(3);
  localparam logic [KEY_W-1:0] KEY_C_DOWN  = KEY_W'(4);
  localparam logic [KEY_W-1:0] KEY_ADJUST  = KEY_W'(5);
  localparam logic [KEY_W-1:0] KEY_MEASURE = KEY_W'(6);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COARSE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(3);

  typedef struct packed {
    logic load_key;
    logic update;
    logic div_start;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_write;
    logic div_last;
  } dp_status_t;

endpackage

>>> src/khsa_ctrl.sv
// ----------------------------------------------------------------------------
// khsa_ctrl
// Tick sequencer: accepts a key beat, runs the key update, drives the
// divider when a converter write is due and loads the output register.
// ----------------------------------------------------------------------------
module khsa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  khsa_pkg::dp_status_t  status,
  output khsa_pkg::ctrl_cmd_t   cmd
);
  import khsa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_CHECK  = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_key = 1'b1;
          state_next   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.need_write) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // output register must be empty or emptying this cycle
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // no key beat is taken while in reset
  assign in_ready = (state == S_IDLE) && !rst;

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == S_DIV))
    else $error("divider start did not enter divide state");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid && in_ready)
    else $error("result load did not set output valid and return to idle");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.load_out)
    else $error("output register overwritten while held");

endmodule

>>> src/khsa_dp.sv
// ----------------------------------------------------------------------------
// khsa_dp
// Configuration registers, key hold and setpoint state, a restoring divider
// (one quotient bit per cycle) and the output register.
// ----------------------------------------------------------------------------
module khsa_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [khsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [khsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [khsa_pkg::KEY_W-1:0]          key_in,
  input  khsa_pkg::ctrl_cmd_t                 cmd,
  output khsa_pkg::dp_status_t                status,
  output logic [khsa_pkg::SP_BITS-1:0]        out_setpoint,
  output logic [khsa_pkg::DAC_BITS-1:0]       out_code,
  output logic                                out_strobe,
  output logic                                out_mode
);
  import khsa_pkg::*;

  logic [SP_BITS-1:0]  max_setpoint;
  logic [HOLD_W-1:0]   hold_ticks;
  logic [COARSE_W-1:0] coarse_step;
  logic [OFFSET_W-1:0] code_offset;

  logic [KEY_W-1:0]    key_reg;
  logic [SP_BITS-1:0]  setpoint;
  logic [HOLD_W-1:0]   hold_count;
  logic                fired;
  logic                mode_reg;
  logic                write_pending;
  logic                strobe_flag;

  logic [SP_BITS-1:0]  setpoint_next;
  logic [HOLD_W-1:0]   hold_count_next;
  logic                fired_next;
  logic                mode_next;
  logic                pending_next;
  logic [SP_BITS:0]    coarse_sum;
  logic [SP_BITS-1:0]  coarse_ext;

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [DIVISOR_W+1:0]  trial;

  logic [DIVIDEND_W-1:0] code_diff;
  logic [DAC_BITS-1:0]   code_final;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_setpoint <= MAX_SP_RST;
      hold_ticks   <= HOLD_RST;
      coarse_step  <= COARSE_RST;
      code_offset  <= OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_SP: max_setpoint <= cfg_data[SP_BITS-1:0];
        REG_HOLD:   hold_ticks   <= cfg_data[HOLD_W-1:0];
        REG_COARSE: coarse_step  <= cfg_data[COARSE_W-1:0];
        REG_OFFSET: code_offset  <= cfg_data[OFFSET_W-1:0];
        default:    ;
      endcase
    end
  end

  assign coarse_ext = SP_BITS'(coarse_step);
  assign coarse_sum = {1'b0, setpoint} + {1'b0, coarse_ext};

  // key hold and action
  always_comb begin
    setpoint_next   = setpoint;
    hold_count_next = hold_count;
    fired_next      = fired;
    mode_next       = mode_reg;
    pending_next    = write_pending;
    if (key_reg == KEY_NONE) begin
      hold_count_next = '0;
      fired_next      = 1'b0;
    end else if (!fired) begin
      if (hold_count < hold_ticks) begin
        hold_count_next = hold_count + HOLD_W'(1);
      end else begin
        fired_next = 1'b1;
        unique case (key_reg)
          KEY_UP: begin
            if (setpoint < max_setpoint) begin
              setpoint_next = setpoint + SP_BITS'(1);
              pending_next  = 1'b1;
            end
          end
          KEY_DOWN: begin
            if (setpoint != '0) begin
              setpoint_next = setpoint - SP_BITS'(1);
              pending_next  = 1'b1;
            end
          end
          KEY_C_UP: begin
            if (coarse_sum < {1'b0, max_setpoint}) begin
              setpoint_next = coarse_sum[SP_BITS-1:0];
              pending_next  = 1'b1;
            end
          end
          KEY_C_DOWN: begin
            if (setpoint > coarse_ext) begin
              setpoint_next = setpoint - coarse_ext;
              pending_next  = 1'b1;
            end
          end
          KEY_ADJUST:  mode_next = 1'b0;
          KEY_MEASURE: mode_next = 1'b1;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_reg <= key_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint      <= SETPOINT_RST;
      hold_count    <= '0;
      fired         <= 1'b0;
      mode_reg      <= 1'b0;
      write_pending <= 1'b1;
      strobe_flag   <= 1'b0;
    end else begin
      if (cmd.update) begin
        setpoint      <= setpoint_next;
        hold_count    <= hold_count_next;
        fired         <= fired_next;
        mode_reg      <= mode_next;
        write_pending <= pending_next;
        strobe_flag   <= 1'b0;
      end
      if (cmd.div_start) begin
        write_pending <= 1'b0;
        strobe_flag   <= 1'b1;
      end
    end
  end

  // restoring divider, msb first
  assign trial = {1'b0, rem, quo[DIVIDEND_W-1]} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= '0;
      quo     <= {setpoint, {DAC_BITS{1'b0}}};
      divisor <= {1'b0, max_setpoint} + DIVISOR_W'(1);
      div_cnt <= DIV_CNT_W'(DIVIDEND_W - 1);
    end else if (cmd.div_step) begin
      if (!trial[DIVISOR_W+1]) begin
        rem <= trial[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIVISOR_W-2:0], quo[DIVIDEND_W-1]};
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  assign status.need_write = !mode_reg && write_pending;
  assign status.div_last   = (div_cnt == '0);

  // offset and saturation, difference only used when quo is above the offset
  assign code_diff = quo - DIVIDEND_W'(code_offset);

  always_comb begin
    if (!strobe_flag || quo <= DIVIDEND_W'(code_offset)) begin
      code_final = '0;
    end else if (|code_diff[DIVIDEND_W-1:DAC_BITS]) begin
      code_final = '1;
    end else begin
      code_final = code_diff[DAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_setpoint <= setpoint;
      out_code     <= code_final;
      out_strobe   <= strobe_flag;
      out_mode     <= mode_reg;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !write_pending && strobe_flag)
    else $error("converter write started but pending mark not cleared");

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> (rem < divisor))
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.update && key_reg == KEY_NONE) |=> (hold_count == '0) && !fired)
    else $error("key release did not re-arm hold logic");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && !strobe_flag) |=> (out_code == '0) && !out_strobe)
    else $error("code issued without a converter write");

endmodule

>>> src/key_hold_setpoint_adjuster.sv
// ----------------------------------------------------------------------------
// key_hold_setpoint_adjuster
// Key-hold setpoint adjuster with converter code scaling.
// ----------------------------------------------------------------------------
// One key beat is one timer tick and yields exactly one result beat. A tick
// with no converter write passes through the update and check states and
// then loads its result; a tick that issues a write also runs the 22-step
// restoring divider between the check and the result load, which forms
// setpoint * 4096 / (max_setpoint + 1) one quotient bit per cycle. A new key
// beat is taken once the previous result sits in the output register, even
// if that result has not been taken yet; the result load waits only while the
// output register still holds an untaken beat. Configuration writes are
// accepted at any time out of reset and should be issued while idle.
module key_hold_setpoint_adjuster (
  input  logic                              clk,
  input  logic                              rst,
  // key tick
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [khsa_pkg::S_TDATA_W-1:0]    s_tdata,   // [4:0] key_number
  // result
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [khsa_pkg::M_TDATA_W-1:0]    m_tdata,   // [9:0] setpoint_value, [21:10] converter_code
  output logic [khsa_pkg::M_TUSER_W-1:0]    m_tuser,   // [0] write_strobe, [1] measure_mode
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [khsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [khsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import khsa_pkg::*;

  ctrl_cmd_t           cmd;
  dp_status_t          status;
  logic [SP_BITS-1:0]  out_setpoint;
  logic [DAC_BITS-1:0] out_code;
  logic                out_strobe;
  logic                out_mode;

  khsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  khsa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .key_in       (s_tdata[KEY_W-1:0]),
    .cmd          (cmd),
    .status       (status),
    .out_setpoint (out_setpoint),
    .out_code     (out_code),
    .out_strobe   (out_strobe),
    .out_mode     (out_mode)
  );

  assign cfg_ready = !rst;
  assign m_tdata   = {{(M_TDATA_W - SP_BITS - DAC_BITS){1'b0}}, out_code, out_setpoint};
  assign m_tuser   = {out_mode, out_strobe};

endmodule
